// File: rtl/rgbp_pkg.sv
package rgbp_pkg;

    localparam int MAX_MESSAGE_BYTES = 256;
    localparam int MAX_FIELD_DIGITS  = 3;

    localparam int POS_W   = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int DIGIT_W = $clog2(MAX_FIELD_DIGITS + 1);
    localparam int VALUE_W = 16;
    localparam int NUM_FIELDS = 3;

    localparam logic [POS_W-1:0]   POS_LIMIT   = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(MAX_FIELD_DIGITS);

    localparam logic [7:0] CLOSE_CHAR = 8'h29;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [VALUE_W-1:0] ASCII_ZERO = VALUE_W'(48);

    localparam logic [2:0] CLOSE_OPEN   = 3'd3;  // field region opens after third ')'
    localparam logic [2:0] CLOSE_DONE   = 3'd4;
    localparam logic [1:0] FIELD_BEYOND = 2'd3;

    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_RED   = 2'd1,
        SEL_GREEN = 2'd2,
        SEL_BLUE  = 2'd3
    } chan_sel_t;

    typedef struct packed {
        logic [2:0]                             close_cnt;
        logic [1:0]                             field_idx;
        logic [NUM_FIELDS-1:0][DIGIT_W-1:0]     digit_cnt;
        logic [NUM_FIELDS-1:0][VALUE_W-1:0]     acc;
        logic                                   stopped;
        logic [POS_W-1:0]                       pos;
    } parse_state_t;

endpackage

// File: rtl/rgbp_step.sv
module rgbp_step
    import rgbp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   message_byte,
    output parse_state_t nxt
);

    logic             take;
    logic             in_region;
    logic [VALUE_W-1:0] byte_ext;

    assign take      = !cur.stopped && (cur.pos < POS_LIMIT);
    assign in_region = (cur.close_cnt == CLOSE_OPEN);
    assign byte_ext  = {{(VALUE_W-8){1'b0}}, message_byte};

    always_comb
    begin
        nxt = cur;
        if (take)
        begin
            nxt.pos = cur.pos + POS_W'(1);
            if (message_byte == NUL_CHAR)
            begin
                nxt.stopped = 1'b1;
            end
            else if (cur.close_cnt < CLOSE_OPEN)
            begin
                if (message_byte == CLOSE_CHAR)
                    nxt.close_cnt = cur.close_cnt + 3'd1;
            end
            else if (in_region)
            begin
                if (message_byte == CLOSE_CHAR)
                begin
                    nxt.close_cnt = CLOSE_DONE;
                end
                else if (message_byte == DOT_CHAR)
                begin
                    if (cur.field_idx != FIELD_BEYOND)
                        nxt.field_idx = cur.field_idx + 2'd1;
                end
                else
                begin
                    for (int i = 0; i < NUM_FIELDS; i++)
                    begin
                        if (cur.field_idx == 2'(i) && cur.digit_cnt[i] < DIGIT_LIMIT)
                        begin
                            // acc*10 as two shifts, wrapped to 16 bits
                            nxt.acc[i] = (cur.acc[i] << 3) + (cur.acc[i] << 1)
                                         + byte_ext - ASCII_ZERO;
                            nxt.digit_cnt[i] = cur.digit_cnt[i] + DIGIT_W'(1);
                        end
                    end
                end
            end
        end
    end

endmodule

// File: rtl/rgb_command_field_parser_unit.sv
// A result appears on the output register in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the per-byte decode and multiply-by-ten accumulate
// fit between the parse state register and the result register.
// Input stalls only while a result is held and the output side stalls.
// Reset (rst_n low, asynchronous) clears parse state and drops out_valid;
// the parse state also returns to reset after every last byte.
module rgb_command_field_parser_unit
    import rgbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          message_byte,
    input  logic                last_byte,
    input  logic [1:0]          channel_select,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VALUE_W-1:0]  red_level,
    output logic [VALUE_W-1:0]  green_level,
    output logic [VALUE_W-1:0]  blue_level,
    output logic [VALUE_W-1:0]  selected_value
);

    parse_state_t       state_reg;
    parse_state_t       state_next;
    logic               accept;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] red_reg;
    logic [VALUE_W-1:0] green_reg;
    logic [VALUE_W-1:0] blue_reg;
    logic [VALUE_W-1:0] sel_reg;
    logic [VALUE_W-1:0] sel_next;

    rgbp_step u_step
    (
        .cur          (state_reg),
        .message_byte (message_byte),
        .nxt          (state_next)
    );

    // output register frees up in the same cycle its beat is taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        case (chan_sel_t'(channel_select))
            SEL_RED:   sel_next = state_next.acc[0];
            SEL_GREEN: sel_next = state_next.acc[1];
            SEL_BLUE:  sel_next = state_next.acc[2];
            default:   sel_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_byte)
                    state_reg <= '0;
                else
                    state_reg <= state_next;
            end
            if (accept && last_byte)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            red_reg   <= state_next.acc[0];
            green_reg <= state_next.acc[1];
            blue_reg  <= state_next.acc[2];
            sel_reg   <= sel_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign red_level      = red_reg;
    assign green_level    = green_reg;
    assign blue_level     = blue_reg;
    assign selected_value = sel_reg;

endmodule
